@@ rtl/spt_pkg.sv @@
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants for stereo point triangulation
// Register indexes, reset values, fixed field widths and pipeline depths used
// by the top level and its arithmetic units.
// ----------------------------------------------------------------------------
package spt_pkg;

   // fixed field widths
   localparam int CSR_W      = 20;  // intrinsic register, unsigned Q12.8
   localparam int PIX_W      = 16;  // pixel coordinate, unsigned Q12.4
   localparam int PIX_FRAC   = 4;   // shift that brings Q12.4 to Q12.8
   localparam int DIF_W      = 21;  // center minus coordinate, signed
   localparam int PRD_W      = 42;  // intrinsic times difference, signed
   localparam int MAG_W      = 41;  // magnitude of a cross term
   localparam int SQ_W       = 41;  // sum of two squared focal lengths
   localparam int POS_W      = 24;  // output coordinate, signed 1/16 mm

   // pipeline shape
   localparam int QUO_BITS   = POS_W;         // quotient bits resolved
   localparam int MUL_STAGES = 3;             // stages of each wide multiplier
   localparam int DIV_LAT    = QUO_BITS + 3;  // register depth of one divider

   // register indexes
   typedef enum logic [2:0] {
      CSR_FOCAL_LEFT_X   = 3'd0,
      CSR_FOCAL_LEFT_Y   = 3'd1,
      CSR_CENTER_LEFT_X  = 3'd2,
      CSR_CENTER_LEFT_Y  = 3'd3,
      CSR_FOCAL_RIGHT_X  = 3'd4,
      CSR_FOCAL_RIGHT_Y  = 3'd5,
      CSR_CENTER_RIGHT_X = 3'd6,
      CSR_CENTER_RIGHT_Y = 3'd7
   } csr_index_type;

   // register reset values
   localparam logic [CSR_W-1:0] RST_FOCAL_LEFT_X   = 20'd336918;
   localparam logic [CSR_W-1:0] RST_FOCAL_LEFT_Y   = 20'd337003;
   localparam logic [CSR_W-1:0] RST_CENTER_LEFT_X  = 20'd129638;
   localparam logic [CSR_W-1:0] RST_CENTER_LEFT_Y  = 20'd95446;
   localparam logic [CSR_W-1:0] RST_FOCAL_RIGHT_X  = 20'd337460;
   localparam logic [CSR_W-1:0] RST_FOCAL_RIGHT_Y  = 20'd337469;
   localparam logic [CSR_W-1:0] RST_CENTER_RIGHT_X = 20'd132366;
   localparam logic [CSR_W-1:0] RST_CENTER_RIGHT_Y = 20'd118687;

   // signs of the cross terms, carried beside the products
   typedef struct packed {
      logic w_neg;
      logic q_neg;
      logic d1_neg;
   } sign_type;

   // signs of the three numerators
   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic z_neg;
   } dir_type;

endpackage

@@ rtl/spt_mul.sv @@
// ----------------------------------------------------------------------------
// spt_mul: pipelined unsigned multiplier
// Splits operand b into STAGES digits and adds one partial product a * digit
// per stage into a running sum.
// ----------------------------------------------------------------------------
module spt_mul #(
   parameter int A_W    = 41,
   parameter int B_W    = 41,
   parameter int STAGES = 3
) (
   input  logic               clock,
   input  logic               en,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);
   import spt_pkg::*;

   localparam int DG_W = (B_W + STAGES - 1) / STAGES;
   localparam int BP_W = DG_W * STAGES;
   localparam int P_W  = A_W + B_W;

   logic [A_W-1:0]  a_ff   [STAGES-1];
   logic [BP_W-1:0] b_ff   [STAGES-1];
   logic [P_W-1:0]  acc_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [A_W-1:0]      a_cur;
      logic [BP_W-1:0]     b_cur;
      logic [P_W-1:0]      acc_cur;
      logic [A_W+DG_W-1:0] part;

      // pick up operands from the previous stage
      if (s == 0) begin : g_first
         assign a_cur   = a;
         assign b_cur   = BP_W'(b);
         assign acc_cur = '0;
      end else begin : g_next
         assign a_cur   = a_ff[s-1];
         assign b_cur   = b_ff[s-1];
         assign acc_cur = acc_ff[s-1];
      end

      // one digit of b per stage
      assign part = a_cur * b_cur[s*DG_W +: DG_W];

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[s] <= acc_cur + (P_W'(part) << (s * DG_W));
         end
      end

      // carry operands forward to the stages that still need them
      if (s < STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               a_ff[s] <= a_cur;
               b_ff[s] <= b_cur;
            end
         end
      end
   end

   assign p = acc_ff[STAGES-1];

endmodule

@@ rtl/spt_div.sv @@
// ----------------------------------------------------------------------------
// spt_div: pipelined rounding divider with saturation
// Forms round(2 * num / (125 * det)) with ties away from zero, one quotient
// bit per stage, then applies the sign and saturates to the output range.
// ----------------------------------------------------------------------------
module spt_div #(
   parameter int NUM_W = 141,
   parameter int DET_W = 124
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [NUM_W-1:0]          num,
   input  logic                      neg,
   input  logic [DET_W-1:0]          det,
   output logic [spt_pkg::POS_W-1:0] code
);
   import spt_pkg::*;

   localparam int DIV_W = DET_W + 8;
   localparam int REM_W = DIV_W + QUO_BITS;
   localparam int N2_W  = NUM_W + 3;
   localparam int CMP_W = (N2_W > REM_W) ? N2_W : REM_W;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] NEG_MAG = {1'b1, {(POS_W-1){1'b0}}};

   logic [N2_W-1:0]     n2_ff;
   logic [DIV_W-1:0]    d2_ff;
   logic                neg_a_ff;
   logic [REM_W-1:0]    rem_b_ff;
   logic [DIV_W-1:0]    d2_b_ff;
   logic                neg_b_ff;
   logic                sat_b_ff;
   logic [REM_W-1:0]    rem_ff   [QUO_BITS-1];
   logic [DIV_W-1:0]    d2_s_ff  [QUO_BITS-1];
   logic [QUO_BITS-1:0] quo_ff   [QUO_BITS];
   logic                neg_s_ff [QUO_BITS];
   logic                sat_s_ff [QUO_BITS];
   logic [POS_W-1:0]    code_ff;
   logic [POS_W-1:0]    code_in;
   logic [POS_W-1:0]    quo_last;
   logic [POS_W-1:0]    neg_mag;

   // scale: numerator gets the half-divisor bias for rounding
   always_ff @(posedge clock) begin
      if (en) begin
         n2_ff    <= (N2_W'(num) << 2) + N2_W'(det) * N2_W'(125);
         d2_ff    <= DIV_W'(det) * DIV_W'(250);
         neg_a_ff <= neg;
      end
   end

   // flag quotients that cannot fit the output range
   always_ff @(posedge clock) begin
      if (en) begin
         sat_b_ff <= CMP_W'(n2_ff) >= (CMP_W'(d2_ff) << QUO_BITS);
         rem_b_ff <= REM_W'(n2_ff);
         d2_b_ff  <= d2_ff;
         neg_b_ff <= neg_a_ff;
      end
   end

   // restoring division, most significant bit first
   for (genvar j = 0; j < QUO_BITS; j++) begin : g_bit
      localparam int SH = QUO_BITS - 1 - j;
      logic [REM_W-1:0]    rem_cur;
      logic [DIV_W-1:0]    d2_cur;
      logic [QUO_BITS-1:0] quo_cur;
      logic                neg_cur;
      logic                sat_cur;
      logic [REM_W:0]      trial;
      logic                ge;

      if (j == 0) begin : g_first
         assign rem_cur = rem_b_ff;
         assign d2_cur  = d2_b_ff;
         assign quo_cur = '0;
         assign neg_cur = neg_b_ff;
         assign sat_cur = sat_b_ff;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign d2_cur  = d2_s_ff[j-1];
         assign quo_cur = quo_ff[j-1];
         assign neg_cur = neg_s_ff[j-1];
         assign sat_cur = sat_s_ff[j-1];
      end

      assign trial = {1'b0, rem_cur} - ({1'b0, REM_W'(d2_cur)} << SH);
      assign ge    = ~trial[REM_W];

      always_ff @(posedge clock) begin
         if (en) begin
            quo_ff[j]   <= {quo_cur[QUO_BITS-2:0], ge};
            neg_s_ff[j] <= neg_cur;
            sat_s_ff[j] <= sat_cur;
         end
      end

      if (j < QUO_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j]  <= ge ? trial[REM_W-1:0] : rem_cur;
               d2_s_ff[j] <= d2_cur;
            end
         end
      end
   end

   // apply sign and clamp to the output range
   assign quo_last = POS_W'(quo_ff[QUO_BITS-1]);
   assign neg_mag  = (sat_s_ff[QUO_BITS-1] ||
                      (quo_last[POS_W-1] && (|quo_last[POS_W-2:0]))) ? NEG_MAG : quo_last;

   always_comb begin
      if (neg_s_ff[QUO_BITS-1]) begin
         code_in = '0 - neg_mag;
      end else if (sat_s_ff[QUO_BITS-1] || quo_last[POS_W-1]) begin
         code_in = POS_MAX;
      end else begin
         code_in = quo_last;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         code_ff <= code_in;
      end
   end

   assign code = code_ff;

endmodule

@@ rtl/stereo_point_triangulation_top.sv @@
// ----------------------------------------------------------------------------
// stereo_point_triangulation_top: linear stereo triangulation pipeline
// Takes one matched pixel pair per beat and returns the 3D point in 1/16 mm.
// The block accepts one pair every cycle unless the result beat is held, and
// returns the results in order; the pipeline depth is set by the three
// layers of three-stage multipliers that build the exact normal-equation
// terms and by the dividers that resolve one quotient bit per stage.
// When the result beat is not taken, the whole pipeline holds, so
// input is accepted whenever the result register is empty or is being taken
// in the same cycle. Intrinsic registers may be written only while no pair
// is in flight; a write takes effect for pairs accepted from the next cycle
// on. A zero determinant returns zero coordinates with rsp_singular set.
// ----------------------------------------------------------------------------
module stereo_point_triangulation_top #(
   parameter int BASELINE_UM = 120000
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_write_en,
   input  spt_pkg::csr_index_type           csr_index,
   input  logic [spt_pkg::CSR_W-1:0]        csr_data,
   // pixel pairs
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [spt_pkg::PIX_W-1:0]        req_left_u,
   input  logic [spt_pkg::PIX_W-1:0]        req_left_v,
   input  logic [spt_pkg::PIX_W-1:0]        req_right_u,
   input  logic [spt_pkg::PIX_W-1:0]        req_right_v,
   // points
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [spt_pkg::POS_W-1:0] rsp_pos_x,
   output logic signed [spt_pkg::POS_W-1:0] rsp_pos_y,
   output logic signed [spt_pkg::POS_W-1:0] rsp_pos_z,
   output logic                             rsp_singular
);
   import spt_pkg::*;

   localparam int K_W      = CSR_W + $clog2(BASELINE_UM + 1);
   localparam int W2_W     = 2 * MAG_W;
   localparam int FW_W     = MAG_W + CSR_W;
   localparam int DWP_W    = MAG_W + DIF_W;
   localparam int GW2_W    = W2_W + SQ_W;
   localparam int T1_W     = W2_W + CSR_W;
   localparam int T2_W     = DWP_W + SQ_W;
   localparam int YM_W     = FW_W + MAG_W;
   localparam int ZM_W     = FW_W + SQ_W;
   localparam int DET_W    = GW2_W + 1;
   localparam int XN_W     = T2_W + 1;
   localparam int XK_W     = XN_W + K_W;
   localparam int YK_W     = YM_W + K_W;
   localparam int ZK_W     = ZM_W + K_W;
   localparam int PIPE_LAT = 5 + 3 * MUL_STAGES + DIV_LAT;

   // intrinsic registers
   logic [CSR_W-1:0] focal_left_x_ff, focal_left_y_ff, center_left_x_ff, center_left_y_ff;
   logic [CSR_W-1:0] focal_right_x_ff, focal_right_y_ff, center_right_x_ff, center_right_y_ff;
   logic [SQ_W-1:0]  g_sum_ff, a_sum_ff;
   logic [K_W-1:0]   k_ff;

   // pipeline control
   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff;

   // difference and cross-term stages
   logic signed [DIF_W-1:0] d1_ff, e1_ff, d2_ff, e2_ff, d1_t2_ff;
   logic signed [PRD_W-1:0] p_f1d2_ff, p_f2d1_ff, p_g1e2_ff, p_g2e1_ff, p_g1e1_ff, p_g2e2_ff;
   logic signed [PRD_W-1:0] w_val, h_val, q_val;
   logic signed [DIF_W-1:0] d1_neg_val;
   logic [MAG_W-1:0]        magw_ff, magh_ff, magq_ff;
   logic [DIF_W-1:0]        magd1_ff;
   sign_type                sign_ff;

   // product layers
   logic [W2_W-1:0]  w2, h2;
   logic [FW_W-1:0]  fw;
   logic [DWP_W-1:0] dwp;
   logic [GW2_W-1:0] gw2, ah2;
   logic [T1_W-1:0]  t1;
   logic [T2_W-1:0]  t2;
   logic [YM_W-1:0]  ym;
   logic [ZM_W-1:0]  zm;
   logic [MAG_W-1:0] magq_dly_ff [MUL_STAGES];
   sign_type         sign_dly_ff [2*MUL_STAGES];

   // numerator stage
   logic [DET_W-1:0] det_ff;
   logic [XN_W-1:0]  xn_ff, xn_in, t1_ext, t2_ext;
   logic [XN_W:0]    x_diff;
   logic             x_neg_in;
   logic [YM_W-1:0]  ym_ff;
   logic [ZM_W-1:0]  zm_ff;
   dir_type          dir_ff;
   sign_type         sign_t9;
   logic [XK_W-1:0]  xk;
   logic [YK_W-1:0]  yk;
   logic [ZK_W-1:0]  zk;
   logic [DET_W-1:0] det_dly_ff [MUL_STAGES];
   dir_type          dir_dly_ff [MUL_STAGES];
   logic             sing_dly_ff [DIV_LAT];

   // output register
   logic [POS_W-1:0] code_x, code_y, code_z;
   logic [POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic             rsp_singular_ff;

   // write intrinsic registers
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_left_x_ff   <= RST_FOCAL_LEFT_X;
         focal_left_y_ff   <= RST_FOCAL_LEFT_Y;
         center_left_x_ff  <= RST_CENTER_LEFT_X;
         center_left_y_ff  <= RST_CENTER_LEFT_Y;
         focal_right_x_ff  <= RST_FOCAL_RIGHT_X;
         focal_right_y_ff  <= RST_FOCAL_RIGHT_Y;
         center_right_x_ff <= RST_CENTER_RIGHT_X;
         center_right_y_ff <= RST_CENTER_RIGHT_Y;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_FOCAL_LEFT_X:   focal_left_x_ff   <= csr_data;
            CSR_FOCAL_LEFT_Y:   focal_left_y_ff   <= csr_data;
            CSR_CENTER_LEFT_X:  center_left_x_ff  <= csr_data;
            CSR_CENTER_LEFT_Y:  center_left_y_ff  <= csr_data;
            CSR_FOCAL_RIGHT_X:  focal_right_x_ff  <= csr_data;
            CSR_FOCAL_RIGHT_Y:  focal_right_y_ff  <= csr_data;
            CSR_CENTER_RIGHT_X: center_right_x_ff <= csr_data;
            CSR_CENTER_RIGHT_Y: center_right_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // derive squared focal sums and scaled baseline from the registers
   always_ff @(posedge clock) begin
      g_sum_ff <= SQ_W'(focal_left_y_ff) * SQ_W'(focal_left_y_ff)
                + SQ_W'(focal_right_y_ff) * SQ_W'(focal_right_y_ff);
      a_sum_ff <= SQ_W'(focal_left_x_ff) * SQ_W'(focal_left_x_ff)
                + SQ_W'(focal_right_x_ff) * SQ_W'(focal_right_x_ff);
      k_ff     <= K_W'(focal_right_x_ff) * K_W'(BASELINE_UM);
   end

   // advance every stage unless the result beat is held
   assign adv       = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   // offsets from the principal points
   always_ff @(posedge clock) begin
      if (adv) begin
         d1_ff <= $signed({1'b0, center_left_x_ff})  - $signed({1'b0, req_left_u,  PIX_FRAC'(0)});
         e1_ff <= $signed({1'b0, center_left_y_ff})  - $signed({1'b0, req_left_v,  PIX_FRAC'(0)});
         d2_ff <= $signed({1'b0, center_right_x_ff}) - $signed({1'b0, req_right_u, PIX_FRAC'(0)});
         e2_ff <= $signed({1'b0, center_right_y_ff}) - $signed({1'b0, req_right_v, PIX_FRAC'(0)});
      end
   end

   // focal length times offset
   always_ff @(posedge clock) begin
      if (adv) begin
         p_f1d2_ff <= $signed({1'b0, focal_left_x_ff})  * d2_ff;
         p_f2d1_ff <= $signed({1'b0, focal_right_x_ff}) * d1_ff;
         p_g1e2_ff <= $signed({1'b0, focal_left_y_ff})  * e2_ff;
         p_g2e1_ff <= $signed({1'b0, focal_right_y_ff}) * e1_ff;
         p_g1e1_ff <= $signed({1'b0, focal_left_y_ff})  * e1_ff;
         p_g2e2_ff <= $signed({1'b0, focal_right_y_ff}) * e2_ff;
         d1_t2_ff  <= d1_ff;
      end
   end

   // cross terms, split into magnitude and sign
   assign w_val      = p_f1d2_ff - p_f2d1_ff;
   assign h_val      = p_g1e2_ff - p_g2e1_ff;
   assign q_val      = p_g1e1_ff + p_g2e2_ff;
   assign d1_neg_val = -d1_t2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         magw_ff        <= w_val[PRD_W-1] ? MAG_W'(-w_val) : MAG_W'(w_val);
         magh_ff        <= h_val[PRD_W-1] ? MAG_W'(-h_val) : MAG_W'(h_val);
         magq_ff        <= q_val[PRD_W-1] ? MAG_W'(-q_val) : MAG_W'(q_val);
         magd1_ff       <= d1_t2_ff[DIF_W-1] ? DIF_W'(d1_neg_val) : DIF_W'(d1_t2_ff);
         sign_ff.w_neg  <= w_val[PRD_W-1];
         sign_ff.q_neg  <= q_val[PRD_W-1];
         sign_ff.d1_neg <= d1_t2_ff[DIF_W-1];
      end
   end

   // first product layer: squares and focal- and offset-weighted cross terms
   spt_mul #(.A_W(MAG_W), .B_W(MAG_W), .STAGES(MUL_STAGES)) u_mul_w2 (
      .clock, .en(adv), .a(magw_ff), .b(magw_ff), .p(w2));
   spt_mul #(.A_W(MAG_W), .B_W(MAG_W), .STAGES(MUL_STAGES)) u_mul_h2 (
      .clock, .en(adv), .a(magh_ff), .b(magh_ff), .p(h2));
   spt_mul #(.A_W(MAG_W), .B_W(CSR_W), .STAGES(MUL_STAGES)) u_mul_fw (
      .clock, .en(adv), .a(magw_ff), .b(focal_left_x_ff), .p(fw));
   spt_mul #(.A_W(MAG_W), .B_W(DIF_W), .STAGES(MUL_STAGES)) u_mul_dw (
      .clock, .en(adv), .a(magw_ff), .b(magd1_ff), .p(dwp));

   // delay side values to line up with the product layers
   always_ff @(posedge clock) begin
      if (adv) begin
         magq_dly_ff[0] <= magq_ff;
         for (int i = 1; i < MUL_STAGES; i++) begin
            magq_dly_ff[i] <= magq_dly_ff[i-1];
         end
         sign_dly_ff[0] <= sign_ff;
         for (int i = 1; i < 2 * MUL_STAGES; i++) begin
            sign_dly_ff[i] <= sign_dly_ff[i-1];
         end
      end
   end

   // second product layer: determinant terms and numerator factors
   spt_mul #(.A_W(W2_W), .B_W(SQ_W), .STAGES(MUL_STAGES)) u_mul_gw2 (
      .clock, .en(adv), .a(w2), .b(g_sum_ff), .p(gw2));
   spt_mul #(.A_W(W2_W), .B_W(SQ_W), .STAGES(MUL_STAGES)) u_mul_ah2 (
      .clock, .en(adv), .a(h2), .b(a_sum_ff), .p(ah2));
   spt_mul #(.A_W(W2_W), .B_W(CSR_W), .STAGES(MUL_STAGES)) u_mul_t1 (
      .clock, .en(adv), .a(h2), .b(focal_right_x_ff), .p(t1));
   spt_mul #(.A_W(DWP_W), .B_W(SQ_W), .STAGES(MUL_STAGES)) u_mul_t2 (
      .clock, .en(adv), .a(dwp), .b(g_sum_ff), .p(t2));
   spt_mul #(.A_W(FW_W), .B_W(MAG_W), .STAGES(MUL_STAGES)) u_mul_ym (
      .clock, .en(adv), .a(fw), .b(magq_dly_ff[MUL_STAGES-1]), .p(ym));
   spt_mul #(.A_W(FW_W), .B_W(SQ_W), .STAGES(MUL_STAGES)) u_mul_zm (
      .clock, .en(adv), .a(fw), .b(g_sum_ff), .p(zm));

   // x numerator: combine terms by sign
   assign sign_t9 = sign_dly_ff[2*MUL_STAGES-1];
   assign t1_ext  = XN_W'(t1);
   assign t2_ext  = XN_W'(t2);
   assign x_diff  = {1'b0, t1_ext} - {1'b0, t2_ext};

   always_comb begin
      priority if (sign_t9.d1_neg != sign_t9.w_neg) begin
         xn_in    = t1_ext + t2_ext;
         x_neg_in = 1'b0;
      end else if (!x_diff[XN_W]) begin
         xn_in    = x_diff[XN_W-1:0];
         x_neg_in = 1'b0;
      end else begin
         xn_in    = t2_ext - t1_ext;
         x_neg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff       <= DET_W'(gw2) + DET_W'(ah2);
         xn_ff        <= xn_in;
         ym_ff        <= ym;
         zm_ff        <= zm;
         dir_ff.x_neg <= x_neg_in;
         dir_ff.y_neg <= sign_t9.q_neg == sign_t9.w_neg;
         dir_ff.z_neg <= sign_t9.w_neg;
      end
   end

   // third product layer: scale numerators by focal length times baseline
   spt_mul #(.A_W(XN_W), .B_W(K_W), .STAGES(MUL_STAGES)) u_mul_xk (
      .clock, .en(adv), .a(xn_ff), .b(k_ff), .p(xk));
   spt_mul #(.A_W(YM_W), .B_W(K_W), .STAGES(MUL_STAGES)) u_mul_yk (
      .clock, .en(adv), .a(ym_ff), .b(k_ff), .p(yk));
   spt_mul #(.A_W(ZM_W), .B_W(K_W), .STAGES(MUL_STAGES)) u_mul_zk (
      .clock, .en(adv), .a(zm_ff), .b(k_ff), .p(zk));

   // delay determinant, signs and singular flag beside the multipliers and dividers
   always_ff @(posedge clock) begin
      if (adv) begin
         det_dly_ff[0] <= det_ff;
         dir_dly_ff[0] <= dir_ff;
         for (int i = 1; i < MUL_STAGES; i++) begin
            det_dly_ff[i] <= det_dly_ff[i-1];
            dir_dly_ff[i] <= dir_dly_ff[i-1];
         end
         sing_dly_ff[0] <= det_dly_ff[MUL_STAGES-1] == '0;
         for (int i = 1; i < DIV_LAT; i++) begin
            sing_dly_ff[i] <= sing_dly_ff[i-1];
         end
      end
   end

   // divide each numerator by the determinant
   spt_div #(.NUM_W(XK_W), .DET_W(DET_W)) u_div_x (
      .clock, .en(adv), .num(xk), .neg(dir_dly_ff[MUL_STAGES-1].x_neg),
      .det(det_dly_ff[MUL_STAGES-1]), .code(code_x));
   spt_div #(.NUM_W(YK_W), .DET_W(DET_W)) u_div_y (
      .clock, .en(adv), .num(yk), .neg(dir_dly_ff[MUL_STAGES-1].y_neg),
      .det(det_dly_ff[MUL_STAGES-1]), .code(code_y));
   spt_div #(.NUM_W(ZK_W), .DET_W(DET_W)) u_div_z (
      .clock, .en(adv), .num(zk), .neg(dir_dly_ff[MUL_STAGES-1].z_neg),
      .det(det_dly_ff[MUL_STAGES-1]), .code(code_z));

   // result register: zero coordinates on a singular system
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_singular_ff <= sing_dly_ff[DIV_LAT-1];
         rsp_pos_x_ff    <= sing_dly_ff[DIV_LAT-1] ? '0 : code_x;
         rsp_pos_y_ff    <= sing_dly_ff[DIV_LAT-1] ? '0 : code_y;
         rsp_pos_z_ff    <= sing_dly_ff[DIV_LAT-1] ? '0 : code_z;
      end
   end

   assign rsp_valid    = vld_ff[PIPE_LAT-1];
   assign rsp_pos_x    = rsp_pos_x_ff;
   assign rsp_pos_y    = rsp_pos_y_ff;
   assign rsp_pos_z    = rsp_pos_z_ff;
   assign rsp_singular = rsp_singular_ff;

`ifndef SYNTH
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_back_press: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result beat is held");
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted beat lost at pipeline entry");
`endif

endmodule
